>>> hdl/segment_pair_intersection_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the segment pair intersection unit.
// ---------------------------------------------------------------------------
`ifndef SEGMENT_PAIR_INTERSECTION_UNIT_ASSERT_SVH
`define SEGMENT_PAIR_INTERSECTION_UNIT_ASSERT_SVH

// Implication checked in the same cycle.
`define SPI_ASSERT_NOW(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Implication checked in the following cycle or after an explicit delay.
`define SPI_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

>>> hdl/spi_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spi_pkg
// Shared widths, item types and helpers of the segment pair intersection unit.
// ---------------------------------------------------------------------------
package spi_pkg;

   localparam int CoordBits   = 16;
   localparam int DiffBits    = CoordBits + 1;
   localparam int ProdBits    = 2 * DiffBits;
   localparam int OrientBits  = ProdBits + 1;
   localparam int LineBits    = 2 * CoordBits + 2;
   localparam int DetBits     = 2 * CoordBits + 3;
   localparam int DetMagBits  = DetBits - 1;
   localparam int NumBits     = 3 * CoordBits + 3;
   localparam int NumMagBits  = NumBits - 1;
   localparam int QuoBits     = CoordBits + 1;
   localparam int PointBits   = QuoBits + 1;
   localparam int FrontStages = 3;
   localparam int Latency     = FrontStages + QuoBits + 1;

   typedef logic signed [CoordBits-1:0] coord_type;
   typedef logic signed [PointBits-1:0] point_type;

   typedef struct packed {
      coord_type first_start_x;
      coord_type first_start_y;
      coord_type first_end_x;
      coord_type first_end_y;
      coord_type second_start_x;
      coord_type second_start_y;
      coord_type second_end_x;
      coord_type second_end_y;
   } spi_req_type;

   typedef struct packed {
      logic      segments_touch;
      logic      has_lattice_point;
      coord_type cross_x;
      coord_type cross_y;
   } spi_rsp_type;

   // Data handed from one divider cell to the next.
   typedef struct packed {
      logic                  valid;
      logic                  touch;
      logic                  ovf;
      logic                  neg_x;
      logic                  neg_y;
      logic [DetMagBits-1:0] divisor;
      logic [DetMagBits-1:0] rem_x;
      logic [DetMagBits-1:0] rem_y;
      logic [QuoBits-1:0]    low_x;
      logic [QuoBits-1:0]    low_y;
      logic [QuoBits-1:0]    quo_x;
      logic [QuoBits-1:0]    quo_y;
      spi_req_type           pair;
   } spi_cell_type;

   function automatic point_type widen(input coord_type c);
      widen = PointBits'(c);
   endfunction

   // Point p lies inside the bounding box of segment a-b.
   function automatic logic in_box(input point_type px, input point_type py,
                                   input coord_type ax, input coord_type ay,
                                   input coord_type bx, input coord_type by);
      point_type axw, ayw, bxw, byw;
      logic      okx, oky;
      axw = widen(ax);
      ayw = widen(ay);
      bxw = widen(bx);
      byw = widen(by);
      okx = ((px <= axw) || (px <= bxw)) && ((px >= axw) || (px >= bxw));
      oky = ((py <= ayw) || (py <= byw)) && ((py >= ayw) || (py >= byw));
      in_box = okx && oky;
   endfunction

endpackage

>>> hdl/segment_pair_intersection_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// segment_pair_intersection_unit
// Touch test and exact lattice crossing of two integer line segments.
// ---------------------------------------------------------------------------
// Usage:
//   An item (two segments, four endpoints) is taken at a rising edge where
//   start is high and busy is low. busy stays low: the unit is fully
//   pipelined and takes one item in every cycle.
//   Each result is shown on rsp_payload for one cycle with rsp_strobe high.
//   Results leave in the order items came in. The pipeline is made of
//   three front stages (products, sums, numerator products), a row of
//   CoordBits + 1 divider cells that each settle one quotient bit of both
//   crossing coordinates, and the output register.
//   The receiver cannot stall, so no result is ever held back.
//   A synchronous reset drops every item in flight; nothing else is kept.
// ---------------------------------------------------------------------------
module segment_pair_intersection_unit
   import spi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  spi_req_type req_payload,
   output logic        rsp_strobe,
   output spi_rsp_type rsp_payload
);

   spi_cell_type chain [QuoBits+1];

   assign busy = 1'b0;

   spi_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start && !busy),
      .in_pair  (req_payload),
      .out_cell (chain[0])
   );

   for (genvar i = 0; i < QuoBits; i++) begin : g_cell
      spi_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_cell  (chain[i]),
         .out_cell (chain[i+1])
      );
   end

   spi_cell_type last;
   point_type    px, py;
   logic         hit;
   logic         strobe_ff;
   spi_rsp_type  rsp_ff, rsp_in;

   always_comb begin
      last = chain[QuoBits];
      px = last.neg_x ? -point_type'({1'b0, last.quo_x}) : point_type'({1'b0, last.quo_x});
      py = last.neg_y ? -point_type'({1'b0, last.quo_y}) : point_type'({1'b0, last.quo_y});
      // The point is on both lines when the division is exact, so the box
      // tests alone decide whether it lies on both segments.
      hit = !last.ovf && (last.rem_x == '0) && (last.rem_y == '0)
         && in_box(px, py, last.pair.first_start_x, last.pair.first_start_y,
                   last.pair.first_end_x, last.pair.first_end_y)
         && in_box(px, py, last.pair.second_start_x, last.pair.second_start_y,
                   last.pair.second_end_x, last.pair.second_end_y);
      rsp_in.segments_touch    = last.touch;
      rsp_in.has_lattice_point = hit;
      rsp_in.cross_x           = hit ? px[CoordBits-1:0] : '0;
      rsp_in.cross_y           = hit ? py[CoordBits-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= last.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;

`include "segment_pair_intersection_unit_assert.svh"

   `SPI_ASSERT_NOW(a_hit_touches, rsp_strobe && rsp_payload.has_lattice_point,
      rsp_payload.segments_touch, "lattice crossing without touching segments")
   `SPI_ASSERT_NOW(a_no_hit_zero, rsp_strobe && !rsp_payload.has_lattice_point,
      (rsp_payload.cross_x == '0) && (rsp_payload.cross_y == '0),
      "crossing point not cleared without a lattice hit")
   `SPI_ASSERT_NOW(a_latency, start && !busy, ##Latency rsp_strobe,
      "accepted item produced no result at the fixed latency")

endmodule

>>> hdl/spi_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spi_front
// Orientation test, line coefficients and numerators; seeds the divider row.
// ---------------------------------------------------------------------------
module spi_front
   import spi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  spi_req_type  in_pair,
   output spi_cell_type out_cell
);

   typedef logic signed [DiffBits-1:0] diff_type;
   typedef logic signed [ProdBits-1:0] prod_type;
   typedef logic signed [LineBits-1:0] line_type;
   typedef logic signed [DetBits-1:0]  det_type;
   typedef logic signed [NumBits-1:0]  num_type;

   function automatic diff_type sub(input coord_type p, input coord_type q);
      sub = DiffBits'(p) - DiffBits'(q);
   endfunction

   function automatic prod_type mul(input diff_type p, input diff_type q);
      prod_type pe, qe;
      pe = ProdBits'(p);
      qe = ProdBits'(q);
      mul = pe * qe;
   endfunction

   // Stage 1: differences and first products.
   logic        v1_ff;
   spi_req_type pair1_ff;
   prod_type    op_ff [8];
   prod_type    lp_ff [4];
   prod_type    dp_ff [2];
   diff_type    a1_ff, b1_ff, a2_ff, b2_ff;

   diff_type a1, b1, a2, b2;
   coord_type ax, ay, bx, by, cx, cy, dx, dy;

   always_comb begin
      ax = in_pair.first_start_x;
      ay = in_pair.first_start_y;
      bx = in_pair.first_end_x;
      by = in_pair.first_end_y;
      cx = in_pair.second_start_x;
      cy = in_pair.second_start_y;
      dx = in_pair.second_end_x;
      dy = in_pair.second_end_y;
      a1 = sub(by, ay);
      b1 = sub(ax, bx);
      a2 = sub(dy, cy);
      b2 = sub(cx, dx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      pair1_ff <= in_pair;
      op_ff[0] <= mul(sub(by, ay), sub(cx, bx));
      op_ff[1] <= mul(sub(bx, ax), sub(cy, by));
      op_ff[2] <= mul(sub(by, ay), sub(dx, bx));
      op_ff[3] <= mul(sub(bx, ax), sub(dy, by));
      op_ff[4] <= mul(sub(dy, cy), sub(ax, dx));
      op_ff[5] <= mul(sub(dx, cx), sub(ay, dy));
      op_ff[6] <= mul(sub(dy, cy), sub(bx, dx));
      op_ff[7] <= mul(sub(dx, cx), sub(by, dy));
      lp_ff[0] <= mul(a1, DiffBits'(ax));
      lp_ff[1] <= mul(b1, DiffBits'(ay));
      lp_ff[2] <= mul(a2, DiffBits'(cx));
      lp_ff[3] <= mul(b2, DiffBits'(cy));
      dp_ff[0] <= mul(a1, b2);
      dp_ff[1] <= mul(a2, b1);
      a1_ff <= a1;
      b1_ff <= b1;
      a2_ff <= a2;
      b2_ff <= b2;
   end

   // Stage 2: orientation signs, touch decision, c1, c2 and determinant.
   logic        v2_ff, touch2_ff;
   spi_req_type pair2_ff;
   line_type    c1_ff, c2_ff;
   det_type     det2_ff;
   diff_type    a1b_ff, b1b_ff, a2b_ff, b2b_ff;

   logic [3:0] oz, on;
   logic       touch2;
   logic       cross_general;

   always_comb begin
      logic signed [OrientBits-1:0] v;
      for (int i = 0; i < 4; i++) begin
         v = OrientBits'(op_ff[2*i]) - OrientBits'(op_ff[2*i+1]);
         oz[i] = (v == '0);
         on[i] = v[OrientBits-1];
      end
      cross_general = ({oz[0], on[0]} != {oz[1], on[1]}) &&
                      ({oz[2], on[2]} != {oz[3], on[3]});
      touch2 = cross_general
         || (oz[0] && in_box(widen(pair1_ff.second_start_x), widen(pair1_ff.second_start_y),
                             pair1_ff.first_start_x, pair1_ff.first_start_y,
                             pair1_ff.first_end_x, pair1_ff.first_end_y))
         || (oz[1] && in_box(widen(pair1_ff.second_end_x), widen(pair1_ff.second_end_y),
                             pair1_ff.first_start_x, pair1_ff.first_start_y,
                             pair1_ff.first_end_x, pair1_ff.first_end_y))
         || (oz[2] && in_box(widen(pair1_ff.first_start_x), widen(pair1_ff.first_start_y),
                             pair1_ff.second_start_x, pair1_ff.second_start_y,
                             pair1_ff.second_end_x, pair1_ff.second_end_y))
         || (oz[3] && in_box(widen(pair1_ff.first_end_x), widen(pair1_ff.first_end_y),
                             pair1_ff.second_start_x, pair1_ff.second_start_y,
                             pair1_ff.second_end_x, pair1_ff.second_end_y));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      touch2_ff <= touch2;
      pair2_ff  <= pair1_ff;
      c1_ff     <= LineBits'(lp_ff[0]) + LineBits'(lp_ff[1]);
      c2_ff     <= LineBits'(lp_ff[2]) + LineBits'(lp_ff[3]);
      det2_ff   <= DetBits'(dp_ff[0]) - DetBits'(dp_ff[1]);
      a1b_ff    <= a1_ff;
      b1b_ff    <= b1_ff;
      a2b_ff    <= a2_ff;
      b2b_ff    <= b2_ff;
   end

   // Stage 3: numerator products. The values fit NumBits by range.
   logic        v3_ff, touch3_ff;
   spi_req_type pair3_ff;
   det_type     det3_ff;
   num_type     np_ff [4];

   function automatic num_type nmul(input diff_type p, input line_type q);
      num_type pe, qe;
      pe = NumBits'(p);
      qe = NumBits'(q);
      nmul = pe * qe;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      touch3_ff <= touch2_ff;
      pair3_ff  <= pair2_ff;
      det3_ff   <= det2_ff;
      np_ff[0]  <= nmul(b2b_ff, c1_ff);
      np_ff[1]  <= nmul(b1b_ff, c2_ff);
      np_ff[2]  <= nmul(a1b_ff, c2_ff);
      np_ff[3]  <= nmul(a2b_ff, c1_ff);
   end

   // Seed of the divider row: magnitudes, signs and the first partial remainder.
   always_comb begin
      num_type                         xn, yn, xa, ya;
      det_type                         da;
      logic [NumMagBits-QuoBits-1:0]   hx, hy;
      xn = np_ff[0] - np_ff[1];
      yn = np_ff[2] - np_ff[3];
      xa = xn[NumBits-1] ? -xn : xn;
      ya = yn[NumBits-1] ? -yn : yn;
      da = det3_ff[DetBits-1] ? -det3_ff : det3_ff;
      hx = xa[NumMagBits-1:QuoBits];
      hy = ya[NumMagBits-1:QuoBits];
      out_cell.valid   = v3_ff;
      out_cell.touch   = touch3_ff;
      out_cell.neg_x   = xn[NumBits-1] ^ det3_ff[DetBits-1];
      out_cell.neg_y   = yn[NumBits-1] ^ det3_ff[DetBits-1];
      out_cell.divisor = da[DetMagBits-1:0];
      out_cell.rem_x   = DetMagBits'(hx);
      out_cell.rem_y   = DetMagBits'(hy);
      // A zero determinant or a quotient too wide for QuoBits quotient bits fails here.
      out_cell.ovf     = (DetMagBits'(hx) >= da[DetMagBits-1:0]) ||
                         (DetMagBits'(hy) >= da[DetMagBits-1:0]);
      out_cell.low_x   = xa[QuoBits-1:0];
      out_cell.low_y   = ya[QuoBits-1:0];
      out_cell.quo_x   = '0;
      out_cell.quo_y   = '0;
      out_cell.pair    = pair3_ff;
   end

endmodule

>>> hdl/spi_div_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spi_div_cell
// One restoring division step for both numerators against the determinant.
// ---------------------------------------------------------------------------
module spi_div_cell
   import spi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  spi_cell_type in_cell,
   output spi_cell_type out_cell
);

   logic                valid_ff;
   spi_cell_type        data_ff;
   spi_cell_type        data_in;
   logic [DetMagBits:0] tx, ty, dv;
   logic                gx, gy;

   always_comb begin
      dv = {1'b0, in_cell.divisor};
      tx = {in_cell.rem_x, in_cell.low_x[QuoBits-1]};
      ty = {in_cell.rem_y, in_cell.low_y[QuoBits-1]};
      gx = (tx >= dv);
      gy = (ty >= dv);
      data_in = in_cell;
      data_in.rem_x = gx ? DetMagBits'(tx - dv) : tx[DetMagBits-1:0];
      data_in.rem_y = gy ? DetMagBits'(ty - dv) : ty[DetMagBits-1:0];
      data_in.low_x = {in_cell.low_x[QuoBits-2:0], 1'b0};
      data_in.low_y = {in_cell.low_y[QuoBits-2:0], 1'b0};
      data_in.quo_x = {in_cell.quo_x[QuoBits-2:0], gx};
      data_in.quo_y = {in_cell.quo_y[QuoBits-2:0], gy};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_cell.valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_comb begin
      out_cell = data_ff;
      out_cell.valid = valid_ff;
   end

endmodule

>>> tb/segment_pair_intersection_unit_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// segment_pair_intersection_unit_test
// Drives segment pairs into the unit and compares every result with an
// independent prediction of the touch test and the lattice crossing point.
// ---------------------------------------------------------------------------
module segment_pair_intersection_unit_test;
   import spi_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   spi_req_type req_payload = '0;
   logic        rsp_strobe;
   spi_rsp_type rsp_payload;

   spi_rsp_type expected_answers[$];
   int          mismatch_count = 0;
   int          answers_seen = 0;
   int          pairs_sent = 0;
   int          send_idle_pct = 0;

   segment_pair_intersection_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_strobe (rsp_strobe),
      .rsp_payload(rsp_payload)
   );

   always #10 clock = ~clock;

   typedef longint signed wide_type;

   function automatic wide_type orient_of(wide_type px, wide_type py, wide_type qx,
                                          wide_type qy, wide_type rx, wide_type ry);
      wide_type v;
      v = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
      return (v == 0) ? 0 : ((v > 0) ? 1 : 2);
   endfunction

   function automatic bit lies_on(wide_type qx, wide_type qy, wide_type ax, wide_type ay,
                                  wide_type bx, wide_type by);
      if (qx > ((ax > bx) ? ax : bx) || qx < ((ax < bx) ? ax : bx)) return 1'b0;
      if (qy > ((ay > by) ? ay : by) || qy < ((ay < by) ? ay : by)) return 1'b0;
      return (qy - ay) * (bx - qx) == (by - qy) * (qx - ax);
   endfunction

   function automatic spi_rsp_type predict_crossing(spi_req_type r);
      spi_rsp_type res;
      wide_type ax, ay, bx, by, cx, cy, dx, dy;
      wide_type o1, o2, o3, o4, a1, b1, c1, a2, b2, c2, det, xn, yn, px, py;
      ax = r.first_start_x;  ay = r.first_start_y;
      bx = r.first_end_x;    by = r.first_end_y;
      cx = r.second_start_x; cy = r.second_start_y;
      dx = r.second_end_x;   dy = r.second_end_y;
      o1 = orient_of(ax, ay, bx, by, cx, cy);
      o2 = orient_of(ax, ay, bx, by, dx, dy);
      o3 = orient_of(cx, cy, dx, dy, ax, ay);
      o4 = orient_of(cx, cy, dx, dy, bx, by);
      res = '0;
      res.segments_touch = (o1 != o2 && o3 != o4)
         || (o1 == 0 && lies_on(cx, cy, ax, ay, bx, by))
         || (o2 == 0 && lies_on(dx, dy, ax, ay, bx, by))
         || (o3 == 0 && lies_on(ax, ay, cx, cy, dx, dy))
         || (o4 == 0 && lies_on(bx, by, cx, cy, dx, dy));
      a1 = by - ay; b1 = ax - bx; c1 = a1 * ax + b1 * ay;
      a2 = dy - cy; b2 = cx - dx; c2 = a2 * cx + b2 * cy;
      det = a1 * b2 - a2 * b1;
      if (det != 0) begin
         xn = b2 * c1 - b1 * c2;
         yn = a1 * c2 - a2 * c1;
         if (xn % det == 0 && yn % det == 0) begin
            px = xn / det;
            py = yn / det;
            if (lies_on(px, py, ax, ay, bx, by) && lies_on(px, py, cx, cy, dx, dy)) begin
               res.has_lattice_point = 1'b1;
               res.cross_x = coord_type'(px);
               res.cross_y = coord_type'(py);
            end
         end
      end
      return res;
   endfunction

   // Results cannot be held off, so every strobe is checked at once.
   always @(posedge clock) begin
      spi_rsp_type want;
      if (!reset && rsp_strobe) begin
         answers_seen++;
         if (expected_answers.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %h", rsp_payload);
         end else begin
            want = expected_answers.pop_front();
            if (rsp_payload.segments_touch !== want.segments_touch
                || rsp_payload.has_lattice_point !== want.has_lattice_point
                || rsp_payload.cross_x !== want.cross_x
                || rsp_payload.cross_y !== want.cross_y) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected t=%b l=%b x=%0d y=%0d, got t=%b l=%b x=%0d y=%0d",
                     want.segments_touch, want.has_lattice_point, want.cross_x,
                     want.cross_y, rsp_payload.segments_touch,
                     rsp_payload.has_lattice_point, rsp_payload.cross_x,
                     rsp_payload.cross_y);
            end
         end
      end
   end

   // Start stays high between back to back items; it drops only while idle.
   task automatic send_pair(spi_req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      req_payload <= r;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_answers.insert(expected_answers.size(), predict_crossing(r));
      pairs_sent++;
      @(negedge clock);
   endtask

   task automatic send_coords(int a, int b, int c, int d, int e, int f, int g, int h);
      spi_req_type r;
      r.first_start_x = coord_type'(a);  r.first_start_y = coord_type'(b);
      r.first_end_x = coord_type'(c);    r.first_end_y = coord_type'(d);
      r.second_start_x = coord_type'(e); r.second_start_y = coord_type'(f);
      r.second_end_x = coord_type'(g);   r.second_end_y = coord_type'(h);
      send_pair(r);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (expected_answers.size() != 0) @(negedge clock);
      repeat (Latency + 4) @(negedge clock);
   endtask

   function automatic coord_type pick_coord(int span);
      if (span == 0) return coord_type'($urandom);
      return coord_type'($urandom_range(2 * span) - span);
   endfunction

   task automatic test_directed();
      send_coords(0, 0, 4, 4, 0, 4, 4, 0);            // proper crossing at (2,2)
      send_coords(0, 0, 3, 0, 0, 1, 3, 2);            // no touch
      send_coords(0, 0, 2, 1, 0, 1, 2, 0);            // crossing off the lattice
      send_coords(0, 0, 4, 0, 2, 0, 6, 0);            // collinear overlap
      send_coords(0, 0, 2, 0, 3, 0, 6, 0);            // collinear, disjoint
      send_coords(0, 0, 4, 4, 1, 0, 5, 4);            // parallel
      send_coords(2, 2, 2, 2, 0, 0, 4, 4);            // point on segment
      send_coords(3, 3, 3, 3, 3, 3, 3, 3);            // two equal points
      send_coords(0, 0, 4, 0, 2, 0, 2, 5);            // T junction at endpoint
      send_coords(0, 0, 1, 1, 5, 0, 5, 9);            // lines cross off segment
      send_coords(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
      send_coords(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
      send_coords(-32768, 0, 32767, 0, 0, -32768, 0, 32767);
      send_coords(-32768, -32768, -32768, 32767, 32767, -32768, -32768, -32768);
      send_coords(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767);
      send_coords(-1, -1, 1, 1, -1, 1, 1, -1);
      drain_results();
   endtask

   task automatic test_random(int count, int idle_pct);
      spi_req_type r;
      int span;
      send_idle_pct = idle_pct;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(3))
            0: span = 0;
            1: span = 8;
            2: span = 64;
            default: span = 2000;
         endcase
         r.first_start_x = pick_coord(span);  r.first_start_y = pick_coord(span);
         r.first_end_x = pick_coord(span);    r.first_end_y = pick_coord(span);
         r.second_start_x = pick_coord(span); r.second_start_y = pick_coord(span);
         r.second_end_x = pick_coord(span);   r.second_end_y = pick_coord(span);
         // Share endpoints now and then to reach the touching cases.
         if ($urandom_range(5) == 0) begin
            r.second_start_x = r.first_end_x;
            r.second_start_y = r.first_end_y;
         end
         send_pair(r);
      end
      send_idle_pct = 0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(350, 0);
      drain_results();
      test_random(330, 76);
      test_random(330, 0);
      test_random(330, 24);
      drain_results();
      $display("Sent %0d segment pairs (directed extremes, random spans, idle mixes);",
         pairs_sent);
      $display("checked %0d results, %0d mismatches.", answers_seen, mismatch_count);
      if (mismatch_count == 0 && expected_answers.size() == 0)
         $display("segment_pair_intersection_unit_test OK");
      else
         $display("segment_pair_intersection_unit_test NOT OK");
      $finish;
   end

   initial begin
      #5ms;
      $display("segment_pair_intersection_unit_test NOT OK");
      $finish;
   end

endmodule
